/* hdl/fxalu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared types and operation codes for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_FROM_INT = 4'd8,
    OP_TO_INT   = 4'd9
  } op_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic a_greater;
    logic a_less;
    logic a_equal;
    logic overflow;
    logic divide_by_zero;
  } rsp_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] a;
    logic [31:0] b;
    logic        neg;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic        gt;
    logic        lt;
    logic        eq;
  } cls_t;

endpackage

/* hdl/fxalu_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxalu_req_if / fxalu_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface fxalu_req_if;
  logic valid;
  logic ready;
  logic [3:0] mode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fxalu_rsp_if;
  logic valid;
  logic ready;
  logic signed [31:0] result;
  logic a_greater;
  logic a_less;
  logic a_equal;
  logic overflow;
  logic divide_by_zero;
  modport source (output valid, result, a_greater, a_less, a_equal, overflow,
                  divide_by_zero, input ready);
  modport sink (input valid, result, a_greater, a_less, a_equal, overflow,
                divide_by_zero, output ready);
endinterface

/* hdl/fxalu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxalu_front
// Accepts requests, computes compare flags, signs and magnitudes.
// ----------------------------------------------------------------------------
module fxalu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fxalu_pkg::req_t    in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output fxalu_pkg::cls_t    out_cls
);
  logic valid;
  fxalu_pkg::cls_t cls;
  fxalu_pkg::cls_t cls_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_cls   = cls;

  always_comb begin
    cls_next.mode  = in_req.mode;
    cls_next.a     = in_req.operand_a;
    cls_next.b     = in_req.operand_b;
    cls_next.neg   = in_req.operand_a[31] ^ in_req.operand_b[31];
    cls_next.mag_a = in_req.operand_a[31] ? 32'(-in_req.operand_a) : in_req.operand_a;
    cls_next.mag_b = in_req.operand_b[31] ? 32'(-in_req.operand_b) : in_req.operand_b;
    cls_next.gt    = in_req.operand_a > in_req.operand_b;
    cls_next.lt    = in_req.operand_a < in_req.operand_b;
    cls_next.eq    = in_req.operand_a == in_req.operand_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      cls <= cls_next;
    end
  end
endmodule

/* hdl/fxalu_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxalu_fifo
// Short queue between front and back.
// ----------------------------------------------------------------------------
module fxalu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic push;
  logic pop;

  assign in_ready  = count != (AW+1)'(DEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end
endmodule

/* hdl/fxalu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxalu_back
// Execution pipeline: multiply stage, then a bit-per-stage restoring divider,
// then rounding, saturation and result select. All items take the same path.
// ----------------------------------------------------------------------------
module fxalu_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fxalu_pkg::cls_t in_cls,
  output logic            out_valid,
  input  logic            out_ready,
  output fxalu_pkg::rsp_t out_rsp
);
  // Quotient of (2n + d) / (2d), n = |a| << FRAC_BITS, fits in QW bits.
  localparam int NW = 33 + FRAC_BITS;
  localparam int QW = NW;
  localparam int NS = QW + 2;

  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] a;
    logic [31:0] b;
    logic        neg;
    logic        gt;
    logic        lt;
    logic        eq;
    logic [63:0] prod;
    logic [NW:0] num;
    logic [33:0] den;
    logic [NW:0] rem;
    logic [NW:0] quo;
  } stg_t;

  stg_t st [NS];
  logic vld [NS];
  logic adv;
  logic rsp_valid;
  stg_t st0_next;
  fxalu_pkg::rsp_t rsp;
  fxalu_pkg::rsp_t rsp_next;

  assign adv       = !rsp_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = rsp_valid;
  assign out_rsp   = rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) vld[i] <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < NS; i++) vld[i] <= vld[i-1];
      rsp_valid <= vld[NS-1];
    end
  end

  // Stage 0: multiply, set up divide numerator 2n + d and denominator 2d.
  always_comb begin
    st0_next.mode = in_cls.mode;
    st0_next.a    = in_cls.a;
    st0_next.b    = in_cls.b;
    st0_next.neg  = in_cls.neg;
    st0_next.gt   = in_cls.gt;
    st0_next.lt   = in_cls.lt;
    st0_next.eq   = in_cls.eq;
    st0_next.prod = 64'(in_cls.mag_a) * 64'(in_cls.mag_b);
    st0_next.num  = ((NW+1)'(in_cls.mag_a) << (FRAC_BITS + 1))
                  + (NW+1)'(in_cls.mag_b);
    st0_next.den  = {1'b0, in_cls.mag_b, 1'b0};
    st0_next.rem  = '0;
    st0_next.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= st0_next;
    end
  end

  // Stages 1..NS-1: one quotient bit each, MSB first.
  for (genvar g = 1; g < NS; g++) begin : g_div
    localparam int BIT = NS - 1 - g;
    logic [NW+1:0] trial;
    stg_t          stage_next;
    always_comb begin
      trial      = {st[g-1].rem, st[g-1].num[BIT]};
      stage_next = st[g-1];
      if (trial >= (NW+2)'(st[g-1].den)) begin
        stage_next.rem      = (NW+1)'(trial - (NW+2)'(st[g-1].den));
        stage_next.quo[BIT] = 1'b1;
      end else begin
        stage_next.rem = trial[NW:0];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st[g] <= stage_next;
      end
    end
  end

  logic [63:0] mq;
  logic [63:0] q;
  logic        qneg;
  logic        sat;
  logic [31:0] sres;
  stg_t        f;

  always_comb begin
    f  = st[NS-1];
    mq = (f.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    q  = (f.mode == fxalu_pkg::OP_MUL) ? mq : 64'(f.quo);
    qneg = f.neg && (q != '0);
    sat  = 1'b0;
    if (qneg) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        sres = 32'h8000_0000;
      end else begin
        sres = 32'(-q);
      end
    end else if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      sres = 32'h7FFF_FFFF;
    end else begin
      sres = q[31:0];
    end

    rsp_next.a_greater      = f.gt;
    rsp_next.a_less         = f.lt;
    rsp_next.a_equal        = f.eq;
    rsp_next.overflow       = 1'b0;
    rsp_next.divide_by_zero = 1'b0;
    case (f.mode)
      fxalu_pkg::OP_ADD:      rsp_next.result = f.a + f.b;
      fxalu_pkg::OP_SUB:      rsp_next.result = f.a - f.b;
      fxalu_pkg::OP_MUL: begin
        rsp_next.result   = sres;
        rsp_next.overflow = sat;
      end
      fxalu_pkg::OP_DIV: begin
        if (f.b == '0) begin
          rsp_next.result         = '0;
          rsp_next.divide_by_zero = 1'b1;
        end else begin
          rsp_next.result   = sres;
          rsp_next.overflow = sat;
        end
      end
      fxalu_pkg::OP_MIN:      rsp_next.result = f.lt ? f.a : f.b;
      fxalu_pkg::OP_MAX:      rsp_next.result = f.gt ? f.a : f.b;
      fxalu_pkg::OP_INC:      rsp_next.result = f.a + 32'd1;
      fxalu_pkg::OP_DEC:      rsp_next.result = f.a - 32'd1;
      fxalu_pkg::OP_FROM_INT: rsp_next.result = f.a << FRAC_BITS;
      fxalu_pkg::OP_TO_INT:   rsp_next.result = $signed(f.a) >>> FRAC_BITS;
      default:                rsp_next.result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && vld[NS-1]) begin
      rsp <= rsp_next;
    end
  end
endmodule

/* hdl/fixed_point_alu_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_top
// Signed fixed-point ALU with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink):  mode, operand_a, operand_b; a request is taken when
//                valid and ready are both high.
//   rsp (source): result plus compare, overflow and divide-by-zero flags,
//                one per request, in request order.
// Throughput: one request per cycle, sustained while rsp.ready stays high.
// Path: the front register loads at the accepting edge, then the queue, the
//   multiply stage, FRAC_BITS + 34 divider stages (one quotient bit each) and
//   the result register, which drives rsp.valid. Every mode takes the same path.
// Stall: when a result waits and rsp.ready is low the back pipeline holds;
//   the queue absorbs requests until full, then req.ready drops.
// Reset: rst clears all valid bits and queue pointers; no result pending.
// ----------------------------------------------------------------------------
module fixed_point_alu_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  fxalu_req_if.sink   req,
  fxalu_rsp_if.source rsp
);
  fxalu_pkg::req_t in_req;
  fxalu_pkg::cls_t f_cls;
  fxalu_pkg::cls_t q_cls;
  fxalu_pkg::rsp_t o_rsp;
  logic f_valid, f_ready, q_valid, q_ready;

  assign in_req.mode      = req.mode;
  assign in_req.operand_a = req.operand_a;
  assign in_req.operand_b = req.operand_b;

  fxalu_front u_front (
    .clk, .rst,
    .in_valid (req.valid), .in_ready (req.ready), .in_req (in_req),
    .out_valid (f_valid), .out_ready (f_ready), .out_cls (f_cls)
  );

  fxalu_fifo #(.WIDTH($bits(fxalu_pkg::cls_t)), .DEPTH(4)) u_fifo (
    .clk, .rst,
    .in_valid (f_valid), .in_ready (f_ready), .in_data (f_cls),
    .out_valid (q_valid), .out_ready (q_ready), .out_data (q_cls)
  );

  fxalu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst,
    .in_valid (q_valid), .in_ready (q_ready), .in_cls (q_cls),
    .out_valid (rsp.valid), .out_ready (rsp.ready), .out_rsp (o_rsp)
  );

  assign rsp.result         = o_rsp.result;
  assign rsp.a_greater      = o_rsp.a_greater;
  assign rsp.a_less         = o_rsp.a_less;
  assign rsp.a_equal        = o_rsp.a_equal;
  assign rsp.overflow       = o_rsp.overflow;
  assign rsp.divide_by_zero = o_rsp.divide_by_zero;
endmodule
